// ----- hdl/gpe_pkg.sv -----
// Shared types, codes and constants of the gate program evaluator.
`timescale 1ns / 1ps

package gpe_pkg;

  localparam int DEF_ENTRY_COUNT  = 262144;
  localparam int DEF_WORD_BITS    = 44;
  localparam int DEF_INPUT_STRIDE = 44;

  localparam int REF_BITS       = 18;
  localparam int OUT_WORD_BITS  = 44;
  localparam int MAX_WORD_BITS  = 64;
  localparam int BIT_INDEX_BITS = 11;
  localparam int STATE_BITS     = 1600;
  localparam int CFG_INDEX_BITS = 2;
  // Wide enough for any entry up to the largest store and any load address.
  localparam int ADDR_W         = 20;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_BASE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_ENTRY = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_GATE,
    OP_ZERO,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    PIN_A,
    PIN_B,
    PIN_C,
    PIN_BAD
  } pin_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_PIN,
    ST_RANGE
  } status_t;

  typedef enum logic [1:0] {
    CK_LOAD,
    CK_GATE,
    CK_ZERO,
    CK_REPORT
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    cmd_kind_t                kind;
    status_t                  status;
    logic                     gate_kind;
    logic [REF_BITS-1:0]      wref;
    logic [ADDR_W-1:0]        waddr;
    logic [ADDR_W-1:0]        laddr;
    logic [ADDR_W-1:0]        raddr;
    pin_t                     lpin;
    pin_t                     rpin;
    logic [MAX_WORD_BITS-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                  status;
    logic [REF_BITS-1:0]      wref;
    logic [OUT_WORD_BITS-1:0] left_word;
    logic [OUT_WORD_BITS-1:0] right_word;
    logic [OUT_WORD_BITS-1:0] gate_word;
  } res_t;

endpackage

// ----- hdl/gpe_front.sv -----
// Front end: configuration registers and classification of incoming words.
`timescale 1ns / 1ps

module gpe_front #(
  parameter int ENTRY_COUNT  = gpe_pkg::DEF_ENTRY_COUNT,
  parameter int WORD_BITS    = gpe_pkg::DEF_WORD_BITS,
  parameter int INPUT_STRIDE = gpe_pkg::DEF_INPUT_STRIDE
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gpe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [gpe_pkg::REF_BITS-1:0]         cfg_data,
  input  logic [1:0]                           in_operation,
  input  logic                                 in_gate_kind,
  input  logic [gpe_pkg::REF_BITS-1:0]         in_target_ref,
  input  logic [gpe_pkg::REF_BITS-1:0]         in_left_ref,
  input  logic [1:0]                           in_left_pin,
  input  logic [gpe_pkg::REF_BITS-1:0]         in_right_ref,
  input  logic [1:0]                           in_right_pin,
  input  logic [gpe_pkg::BIT_INDEX_BITS-1:0]   in_bit_index,
  input  logic [gpe_pkg::OUT_WORD_BITS-1:0]    in_load_value,
  output gpe_pkg::cmd_t                        cmd
);

  localparam int AW = gpe_pkg::ADDR_W;
  localparam logic [AW:0] ENTRY_LIMIT = (AW + 1)'(ENTRY_COUNT);

  logic [gpe_pkg::REF_BITS-1:0] input_base_r;
  logic [gpe_pkg::REF_BITS-1:0] zero_entry_r;

  logic [AW-1:0]     load_addr;
  logic              load_range;
  logic              gate_range;
  gpe_pkg::pin_t     lpin;
  gpe_pkg::pin_t     rpin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_base_r <= '0;
      zero_entry_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == gpe_pkg::REG_INPUT_BASE) input_base_r <= cfg_data;
      if (cfg_index == gpe_pkg::REG_ZERO_ENTRY) zero_entry_r <= cfg_data;
    end
  end

  assign lpin = gpe_pkg::pin_t'(in_left_pin);
  assign rpin = gpe_pkg::pin_t'(in_right_pin);

  assign load_addr  = AW'(input_base_r) + AW'(in_bit_index) * AW'(INPUT_STRIDE);
  assign load_range = (in_bit_index >= gpe_pkg::BIT_INDEX_BITS'(gpe_pkg::STATE_BITS)) ||
                      ({1'b0, load_addr} >= ENTRY_LIMIT);
  assign gate_range = ((AW + 1)'(in_target_ref) >= ENTRY_LIMIT) ||
                      ((AW + 1)'(in_left_ref) >= ENTRY_LIMIT) ||
                      ((AW + 1)'(in_right_ref) >= ENTRY_LIMIT);

  always_comb begin
    cmd           = '0;
    cmd.kind      = gpe_pkg::CK_REPORT;
    cmd.status    = gpe_pkg::ST_OK;
    cmd.gate_kind = in_gate_kind;
    cmd.lpin      = lpin;
    cmd.rpin      = rpin;
    cmd.value     = gpe_pkg::MAX_WORD_BITS'(WORD_BITS'(in_load_value));
    case (gpe_pkg::op_t'(in_operation))
      gpe_pkg::OP_LOAD: begin
        cmd.wref  = load_addr[gpe_pkg::REF_BITS-1:0];
        cmd.waddr = load_addr;
        cmd.laddr = load_addr;
        cmd.raddr = load_addr;
        if (load_range) begin
          cmd.status = gpe_pkg::ST_RANGE;
        end else begin
          cmd.kind = gpe_pkg::CK_LOAD;
        end
      end
      gpe_pkg::OP_GATE: begin
        cmd.wref  = in_target_ref;
        cmd.waddr = AW'(in_target_ref);
        cmd.laddr = AW'(in_left_ref);
        cmd.raddr = AW'(in_right_ref);
        // The pin check takes precedence over the range check.
        if (lpin == gpe_pkg::PIN_BAD || rpin == gpe_pkg::PIN_BAD) begin
          cmd.status = gpe_pkg::ST_BAD_PIN;
        end else if (gate_range) begin
          cmd.status = gpe_pkg::ST_RANGE;
        end else begin
          cmd.kind = gpe_pkg::CK_GATE;
        end
      end
      gpe_pkg::OP_ZERO: begin
        cmd.wref  = zero_entry_r;
        cmd.waddr = AW'(zero_entry_r);
        cmd.laddr = AW'(zero_entry_r);
        cmd.raddr = AW'(zero_entry_r);
        if ((AW + 1)'(zero_entry_r) >= ENTRY_LIMIT) begin
          cmd.status = gpe_pkg::ST_RANGE;
        end else begin
          cmd.kind = gpe_pkg::CK_ZERO;
        end
      end
      default: begin
        cmd.kind = gpe_pkg::CK_REPORT;
      end
    endcase
  end

endmodule

// ----- hdl/gpe_cmd_queue.sv -----
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps

module gpe_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gpe_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output gpe_pkg::cmd_t rdata,
  output logic          empty
);

  localparam int PTR_W = $clog2(gpe_pkg::CMD_DEPTH);
  localparam int CNT_W = $clog2(gpe_pkg::CMD_DEPTH + 1);

  gpe_pkg::cmd_t    slot_r [gpe_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(gpe_pkg::CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // The depth is a power of two, so the pointers simply wrap.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

// ----- hdl/gpe_back.sv -----
// Back end: the three word stores, gate execution and the result queue.
`timescale 1ns / 1ps

module gpe_back #(
  parameter int ENTRY_COUNT = gpe_pkg::DEF_ENTRY_COUNT,
  parameter int WORD_BITS   = gpe_pkg::DEF_WORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  gpe_pkg::cmd_t                       q_rdata,
  output logic                                q_pop,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [1:0]                          out_status,
  output logic [gpe_pkg::REF_BITS-1:0]        out_written_ref,
  output logic [gpe_pkg::OUT_WORD_BITS-1:0]   out_left_word,
  output logic [gpe_pkg::OUT_WORD_BITS-1:0]   out_right_word,
  output logic [gpe_pkg::OUT_WORD_BITS-1:0]   out_gate_word
);

  localparam int MEM_AW    = $clog2(ENTRY_COUNT);
  localparam int RES_PTR_W = $clog2(gpe_pkg::RES_DEPTH);
  localparam int RES_CNT_W = $clog2(gpe_pkg::RES_DEPTH + 1);

  logic [WORD_BITS-1:0] a_mem [ENTRY_COUNT];
  logic [WORD_BITS-1:0] b_mem [ENTRY_COUNT];
  logic [WORD_BITS-1:0] c_mem [ENTRY_COUNT];

  gpe_pkg::back_state_t state_r, state_nxt;
  gpe_pkg::cmd_t        cur_r;

  // Read data: the L port reads at laddr, the R port at raddr.
  logic [WORD_BITS-1:0] a_l_r, b_l_r, c_l_r;
  logic [WORD_BITS-1:0] a_r_r, b_r_r, c_r_r;

  logic                 we_a, we_b, we_c;
  logic [WORD_BITS-1:0] a_new, b_new, c_new;
  logic [WORD_BITS-1:0] a_src, b_src;

  gpe_pkg::res_t        res_slot_r [gpe_pkg::RES_DEPTH];
  gpe_pkg::res_t        res_nxt;
  logic [RES_PTR_W-1:0] res_wr_r, res_rd_r;
  logic [RES_CNT_W-1:0] res_count_r;
  logic                 res_push;
  logic                 res_pop;

  function automatic logic [WORD_BITS-1:0] pick(
    gpe_pkg::pin_t        pin,
    logic [WORD_BITS-1:0] a,
    logic [WORD_BITS-1:0] b,
    logic [WORD_BITS-1:0] c
  );
    logic [WORD_BITS-1:0] w;
    case (pin)
      gpe_pkg::PIN_A: w = a;
      gpe_pkg::PIN_B: w = b;
      default:        w = c;
    endcase
    return w;
  endfunction

  // The left copy lands before the right source is read, so a right read of
  // store A at the target entry sees the new left value.
  always_comb begin
    a_src = pick(cur_r.lpin, a_l_r, b_l_r, c_l_r);
    if (cur_r.rpin == gpe_pkg::PIN_A && cur_r.raddr == cur_r.waddr) begin
      b_src = a_src;
    end else begin
      b_src = pick(cur_r.rpin, a_r_r, b_r_r, c_r_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    res_push  = 1'b0;
    we_a      = 1'b0;
    we_b      = 1'b0;
    we_c      = 1'b0;
    a_new     = '0;
    b_new     = '0;
    c_new     = '0;
    res_nxt          = '0;
    res_nxt.status   = cur_r.status;
    res_nxt.wref     = cur_r.wref;
    case (state_r)
      gpe_pkg::BK_IDLE: begin
        if (!q_empty && res_count_r < RES_CNT_W'(gpe_pkg::RES_DEPTH)) begin
          q_pop     = 1'b1;
          state_nxt = gpe_pkg::BK_EXEC;
        end
      end
      gpe_pkg::BK_EXEC: begin
        res_push  = 1'b1;
        state_nxt = gpe_pkg::BK_IDLE;
        case (cur_r.kind)
          gpe_pkg::CK_LOAD: begin
            we_a  = 1'b1;
            a_new = WORD_BITS'(cur_r.value);
            res_nxt.left_word  = gpe_pkg::OUT_WORD_BITS'(a_new);
            res_nxt.right_word = gpe_pkg::OUT_WORD_BITS'(b_l_r);
            res_nxt.gate_word  = gpe_pkg::OUT_WORD_BITS'(c_l_r);
          end
          gpe_pkg::CK_GATE: begin
            we_a  = 1'b1;
            we_b  = 1'b1;
            we_c  = 1'b1;
            a_new = a_src;
            b_new = b_src;
            c_new = cur_r.gate_kind ? (~a_src & b_src) : (a_src ^ b_src);
            res_nxt.left_word  = gpe_pkg::OUT_WORD_BITS'(a_new);
            res_nxt.right_word = gpe_pkg::OUT_WORD_BITS'(b_new);
            res_nxt.gate_word  = gpe_pkg::OUT_WORD_BITS'(c_new);
          end
          gpe_pkg::CK_ZERO: begin
            we_a  = 1'b1;
            we_b  = 1'b1;
            we_c  = 1'b1;
            a_new = '0;
            b_new = '1;
            c_new = '1;
            res_nxt.left_word  = gpe_pkg::OUT_WORD_BITS'(a_new);
            res_nxt.right_word = gpe_pkg::OUT_WORD_BITS'(b_new);
            res_nxt.gate_word  = gpe_pkg::OUT_WORD_BITS'(c_new);
          end
          default: begin
            // Flagged or unused operations write nothing and report zero words.
          end
        endcase
      end
      default: begin
        state_nxt = gpe_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpe_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_rdata;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_l_r <= a_mem[q_rdata.laddr[MEM_AW-1:0]];
      b_l_r <= b_mem[q_rdata.laddr[MEM_AW-1:0]];
      c_l_r <= c_mem[q_rdata.laddr[MEM_AW-1:0]];
      a_r_r <= a_mem[q_rdata.raddr[MEM_AW-1:0]];
      b_r_r <= b_mem[q_rdata.raddr[MEM_AW-1:0]];
      c_r_r <= c_mem[q_rdata.raddr[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) a_mem[cur_r.waddr[MEM_AW-1:0]] <= a_new;
    if (we_b) b_mem[cur_r.waddr[MEM_AW-1:0]] <= b_new;
    if (we_c) c_mem[cur_r.waddr[MEM_AW-1:0]] <= c_new;
  end

  // Result queue; its depth is a power of two so the pointers wrap.
  assign out_empty       = (res_count_r == '0);
  assign res_pop         = out_pop && !out_empty;
  assign out_status      = res_slot_r[res_rd_r].status;
  assign out_written_ref = res_slot_r[res_rd_r].wref;
  assign out_left_word   = res_slot_r[res_rd_r].left_word;
  assign out_right_word  = res_slot_r[res_rd_r].right_word;
  assign out_gate_word   = res_slot_r[res_rd_r].gate_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r    <= '0;
      res_rd_r    <= '0;
      res_count_r <= '0;
    end else begin
      if (res_push) res_wr_r <= res_wr_r + 1'b1;
      if (res_pop) res_rd_r <= res_rd_r + 1'b1;
      res_count_r <= res_count_r + RES_CNT_W'(res_push) - RES_CNT_W'(res_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) res_slot_r[res_wr_r] <= res_nxt;
  end

  a_store_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (we_a || we_b || we_c) |-> (state_r == gpe_pkg::BK_EXEC))
    else $error("store written outside the execute cycle");

  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> res_push)
    else $error("issued command produced no result word");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_count_r < RES_CNT_W'(gpe_pkg::RES_DEPTH)))
    else $error("result queue overflow");

  a_flagged_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_nxt.status != gpe_pkg::ST_OK) |->
      (!we_a && !we_b && !we_c && res_nxt.left_word == '0 &&
       res_nxt.right_word == '0 && res_nxt.gate_word == '0))
    else $error("flagged word wrote a store or reported data");

endmodule

// ----- hdl/gate_program_evaluator.sv -----
// Top level of the gate program evaluator: front end, command queue, back end.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      push / full            operation, gate kind, refs, pins, load word
//   out_     output     empty / pop            status, written ref, three store words
//   cfg_     input      valid / ready          register index, 18-bit data
//
// For each item the back end first reads all three stores at the left and right
// addresses, then writes the target entry and queues the result before taking the next.
// Classification is combinational and a two-word command queue sits in between.
// Reset clears the configuration registers and the queue and state control only;
// the stores are not cleared and hold nothing defined until written.
// A stalled result side fills the result queue and then the command queue,
// after which full rises.
`timescale 1ns / 1ps

module gate_program_evaluator #(
  parameter int ENTRY_COUNT  = gpe_pkg::DEF_ENTRY_COUNT,
  parameter int WORD_BITS    = gpe_pkg::DEF_WORD_BITS,
  parameter int INPUT_STRIDE = gpe_pkg::DEF_INPUT_STRIDE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gpe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [gpe_pkg::REF_BITS-1:0]        cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [1:0]                          in_operation,
  input  logic                                in_gate_kind,
  input  logic [gpe_pkg::REF_BITS-1:0]        in_target_ref,
  input  logic [gpe_pkg::REF_BITS-1:0]        in_left_ref,
  input  logic [1:0]                          in_left_pin,
  input  logic [gpe_pkg::REF_BITS-1:0]        in_right_ref,
  input  logic [1:0]                          in_right_pin,
  input  logic [gpe_pkg::BIT_INDEX_BITS-1:0]  in_bit_index,
  input  logic [gpe_pkg::OUT_WORD_BITS-1:0]   in_load_value,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [1:0]                          out_status,
  output logic [gpe_pkg::REF_BITS-1:0]        out_written_ref,
  output logic [gpe_pkg::OUT_WORD_BITS-1:0]   out_left_word,
  output logic [gpe_pkg::OUT_WORD_BITS-1:0]   out_right_word,
  output logic [gpe_pkg::OUT_WORD_BITS-1:0]   out_gate_word
);

  gpe_pkg::cmd_t front_cmd;
  gpe_pkg::cmd_t q_rdata;
  logic          q_empty;
  logic          q_pop;

  gpe_front #(
    .ENTRY_COUNT  (ENTRY_COUNT),
    .WORD_BITS    (WORD_BITS),
    .INPUT_STRIDE (INPUT_STRIDE)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_operation  (in_operation),
    .in_gate_kind  (in_gate_kind),
    .in_target_ref (in_target_ref),
    .in_left_ref   (in_left_ref),
    .in_left_pin   (in_left_pin),
    .in_right_ref  (in_right_ref),
    .in_right_pin  (in_right_pin),
    .in_bit_index  (in_bit_index),
    .in_load_value (in_load_value),
    .cmd           (front_cmd)
  );

  gpe_cmd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  gpe_back #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .WORD_BITS   (WORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_status      (out_status),
    .out_written_ref (out_written_ref),
    .out_left_word   (out_left_word),
    .out_right_word  (out_right_word),
    .out_gate_word   (out_gate_word)
  );

endmodule

// ----- verif/tb_gate_program_evaluator.sv -----
// Self-checking testbench of the gate program evaluator, with its own store predictor.
`timescale 1ns / 1ps

module tb_gate_program_evaluator;

  localparam int REF_BITS         = gpe_pkg::REF_BITS;
  localparam int OUT_WORD_BITS    = gpe_pkg::OUT_WORD_BITS;
  localparam int BIT_INDEX_BITS   = gpe_pkg::BIT_INDEX_BITS;
  localparam int CFG_INDEX_BITS   = gpe_pkg::CFG_INDEX_BITS;
  localparam int STATE_BITS       = gpe_pkg::STATE_BITS;
  localparam int DEF_ENTRY_COUNT  = gpe_pkg::DEF_ENTRY_COUNT;
  localparam int DEF_INPUT_STRIDE = gpe_pkg::DEF_INPUT_STRIDE;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_BIT_INDEX = (1 << BIT_INDEX_BITS) - 1;
  localparam logic [OUT_WORD_BITS-1:0] ALL_ONES = '1;

  typedef struct {
    gpe_pkg::op_t              op;
    logic                      kind;
    logic [REF_BITS-1:0]       tref;
    logic [REF_BITS-1:0]       lref;
    gpe_pkg::pin_t             lpin;
    logic [REF_BITS-1:0]       rref;
    gpe_pkg::pin_t             rpin;
    logic [BIT_INDEX_BITS-1:0] bit_idx;
    logic [OUT_WORD_BITS-1:0]  value;
  } gate_item_t;

  typedef struct {
    gpe_pkg::status_t         status;
    logic [REF_BITS-1:0]      wref;
    logic [OUT_WORD_BITS-1:0] left_word;
    logic [OUT_WORD_BITS-1:0] right_word;
    logic [OUT_WORD_BITS-1:0] gate_word;
  } gate_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [CFG_INDEX_BITS-1:0]        cfg_index = gpe_pkg::REG_INPUT_BASE;
  logic [REF_BITS-1:0]              cfg_data = '0;
  logic                             in_push = 1'b0;
  logic                             in_full;
  logic [1:0]                       in_operation = '0;
  logic                             in_gate_kind = 1'b0;
  logic [REF_BITS-1:0]              in_target_ref = '0;
  logic [REF_BITS-1:0]              in_left_ref = '0;
  logic [1:0]                       in_left_pin = '0;
  logic [REF_BITS-1:0]              in_right_ref = '0;
  logic [1:0]                       in_right_pin = '0;
  logic [BIT_INDEX_BITS-1:0]        in_bit_index = '0;
  logic [OUT_WORD_BITS-1:0]         in_load_value = '0;
  logic                             out_empty;
  logic                             out_pop = 1'b0;
  logic [1:0]                       out_status;
  logic [REF_BITS-1:0]              out_written_ref;
  logic [OUT_WORD_BITS-1:0]         out_left_word;
  logic [OUT_WORD_BITS-1:0]         out_right_word;
  logic [OUT_WORD_BITS-1:0]         out_gate_word;

  // Predictor state: the three stores, the registers and the entries known to be fully written.
  logic [OUT_WORD_BITS-1:0] pin_a_words[int];
  logic [OUT_WORD_BITS-1:0] pin_b_words[int];
  logic [OUT_WORD_BITS-1:0] gate_c_words[int];
  logic [REF_BITS-1:0]      base_ref = '0;
  logic [REF_BITS-1:0]      zero_ref = '0;
  bit                       live_map[int];
  int                       live_refs[$];
  int                       lane_bits[$];

  gate_result_t gate_results_due[$];
  int           mismatches = 0;
  bit           idle_on = 1'b1;
  int           hold_request = 0;
  int           hold_left = 0;
  int           stall_left = 0;

  gate_program_evaluator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_operation    (in_operation),
    .in_gate_kind    (in_gate_kind),
    .in_target_ref   (in_target_ref),
    .in_left_ref     (in_left_ref),
    .in_left_pin     (in_left_pin),
    .in_right_ref    (in_right_ref),
    .in_right_pin    (in_right_pin),
    .in_bit_index    (in_bit_index),
    .in_load_value   (in_load_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_status      (out_status),
    .out_written_ref (out_written_ref),
    .out_left_word   (out_left_word),
    .out_right_word  (out_right_word),
    .out_gate_word   (out_gate_word)
  );

  always #5 clk = ~clk;

  function automatic logic [OUT_WORD_BITS-1:0] read_store(gpe_pkg::pin_t pin, int entry);
    case (pin)
      gpe_pkg::PIN_A: return pin_a_words.exists(entry) ? pin_a_words[entry] : '0;
      gpe_pkg::PIN_B: return pin_b_words.exists(entry) ? pin_b_words[entry] : '0;
      default:        return gate_c_words.exists(entry) ? gate_c_words[entry] : '0;
    endcase
  endfunction

  function automatic void mark_live(int entry);
    if (!live_map.exists(entry)) begin
      live_map[entry] = 1'b1;
      live_refs = {live_refs, entry};
    end
  endfunction

  function automatic gate_result_t stored_result(int entry);
    gate_result_t res;
    res.status     = gpe_pkg::ST_OK;
    res.wref       = entry[REF_BITS-1:0];
    res.left_word  = read_store(gpe_pkg::PIN_A, entry);
    res.right_word = read_store(gpe_pkg::PIN_B, entry);
    res.gate_word  = read_store(gpe_pkg::PIN_C, entry);
    return res;
  endfunction

  // Applies one accepted word to the predicted stores and returns the result it must produce.
  function automatic gate_result_t evaluate_gate_item(gate_item_t it);
    gate_result_t             res;
    int                       addr;
    logic [OUT_WORD_BITS-1:0] lw;
    logic [OUT_WORD_BITS-1:0] rw;
    res = '{gpe_pkg::ST_OK, '0, '0, '0, '0};
    case (it.op)
      gpe_pkg::OP_LOAD: begin
        addr = int'(base_ref) + int'(it.bit_idx) * DEF_INPUT_STRIDE;
        if (int'(it.bit_idx) >= STATE_BITS || addr >= DEF_ENTRY_COUNT) begin
          res.status = gpe_pkg::ST_RANGE;
          res.wref   = addr[REF_BITS-1:0];
        end else begin
          pin_a_words[addr] = it.value;
          res = stored_result(addr);
        end
      end
      gpe_pkg::OP_GATE: begin
        if (it.lpin == gpe_pkg::PIN_BAD || it.rpin == gpe_pkg::PIN_BAD) begin
          res.status = gpe_pkg::ST_BAD_PIN;
          res.wref   = it.tref;
        end else begin
          // The left copy lands before the right source is read.
          lw = read_store(it.lpin, int'(it.lref));
          pin_a_words[int'(it.tref)] = lw;
          rw = read_store(it.rpin, int'(it.rref));
          pin_b_words[int'(it.tref)] = rw;
          gate_c_words[int'(it.tref)] = it.kind ? (~lw & rw) : (lw ^ rw);
          mark_live(int'(it.tref));
          res = stored_result(int'(it.tref));
        end
      end
      gpe_pkg::OP_ZERO: begin
        pin_a_words[int'(zero_ref)]  = '0;
        pin_b_words[int'(zero_ref)]  = ALL_ONES;
        gate_c_words[int'(zero_ref)] = ALL_ONES;
        mark_live(int'(zero_ref));
        res = stored_result(int'(zero_ref));
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [OUT_WORD_BITS-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      default: return OUT_WORD_BITS'({$urandom(), $urandom()});
    endcase
  endfunction

  // Random fields everywhere; the unused operation unless a caller overrides it.
  function automatic gate_item_t noise_item();
    gate_item_t it;
    it.op      = gpe_pkg::OP_NONE;
    it.kind    = 1'($urandom());
    it.tref    = REF_BITS'($urandom());
    it.lref    = REF_BITS'($urandom());
    it.lpin    = gpe_pkg::pin_t'($urandom_range(0, 3));
    it.rref    = REF_BITS'($urandom());
    it.rpin    = gpe_pkg::pin_t'($urandom_range(0, 3));
    it.bit_idx = BIT_INDEX_BITS'($urandom());
    it.value   = OUT_WORD_BITS'({$urandom(), $urandom()});
    return it;
  endfunction

  function automatic gate_item_t gate_item(logic kind, logic [REF_BITS-1:0] tref,
                                           logic [REF_BITS-1:0] lref, gpe_pkg::pin_t lpin,
                                           logic [REF_BITS-1:0] rref, gpe_pkg::pin_t rpin);
    gate_item_t it;
    it      = noise_item();
    it.op   = gpe_pkg::OP_GATE;
    it.kind = kind;
    it.tref = tref;
    it.lref = lref;
    it.lpin = lpin;
    it.rref = rref;
    it.rpin = rpin;
    return it;
  endfunction

  function automatic gate_item_t load_item(int bit_no, logic [OUT_WORD_BITS-1:0] value);
    gate_item_t it;
    it         = noise_item();
    it.op      = gpe_pkg::OP_LOAD;
    it.bit_idx = BIT_INDEX_BITS'(bit_no);
    it.value   = value;
    return it;
  endfunction

  function automatic gate_item_t zero_item();
    gate_item_t it;
    it    = noise_item();
    it.op = gpe_pkg::OP_ZERO;
    return it;
  endfunction

  function automatic int pick_live();
    return live_refs[$urandom_range(0, live_refs.size() - 1)];
  endfunction

  // A gate whose sources are entries already written in all three stores.
  function automatic gate_item_t pool_gate(logic [REF_BITS-1:0] target);
    return gate_item(1'($urandom()), target,
                     REF_BITS'(pick_live()), gpe_pkg::pin_t'($urandom_range(0, 2)),
                     REF_BITS'(pick_live()), gpe_pkg::pin_t'($urandom_range(0, 2)));
  endfunction

  function automatic gate_item_t random_item();
    gate_item_t it;
    int         pick;
    int         lo;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      it = pool_gate($urandom_range(0, 2) == 0 ? REF_BITS'($urandom())
                                               : REF_BITS'(pick_live()));
      // The right pin reading the target's fresh left copy is always defined.
      if ($urandom_range(0, 9) == 0) begin
        it.rref = it.tref;
        it.rpin = gpe_pkg::PIN_A;
      end
    end else if (pick < 72) begin
      it = load_item(lane_bits[$urandom_range(0, lane_bits.size() - 1)], random_word());
    end else if (pick < 78) begin
      it = zero_item();
    end else if (pick < 86) begin
      it    = noise_item();
      it.op = gpe_pkg::OP_GATE;
      case ($urandom_range(0, 2))
        0:       it.lpin = gpe_pkg::PIN_BAD;
        1:       it.rpin = gpe_pkg::PIN_BAD;
        default: begin
          it.lpin = gpe_pkg::PIN_BAD;
          it.rpin = gpe_pkg::PIN_BAD;
        end
      endcase
    end else if (pick < 93) begin
      lo = (DEF_ENTRY_COUNT - int'(base_ref) + DEF_INPUT_STRIDE - 1) / DEF_INPUT_STRIDE;
      if (lo < STATE_BITS && $urandom_range(0, 1) == 1)
        it = load_item($urandom_range(lo, STATE_BITS - 1), random_word());
      else
        it = load_item($urandom_range(STATE_BITS, MAX_BIT_INDEX), random_word());
    end else begin
      it = noise_item();
    end
    return it;
  endfunction

  // Offers one word and waits until the block takes it. The push stays high unless a gap follows.
  task automatic send_word(gate_item_t it);
    in_operation  <= it.op;
    in_gate_kind  <= it.kind;
    in_target_ref <= it.tref;
    in_left_ref   <= it.lref;
    in_left_pin   <= it.lpin;
    in_right_ref  <= it.rref;
    in_right_pin  <= it.rpin;
    in_bit_index  <= it.bit_idx;
    in_load_value <= it.value;
    in_push       <= 1'b1;
    do @(posedge clk); while (in_full !== 1'b0);
    gate_results_due = {gate_results_due, evaluate_gate_item(it)};
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (gate_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [REF_BITS-1:0] base, logic [REF_BITS-1:0] zero);
    cfg_index <= gpe_pkg::REG_INPUT_BASE;
    cfg_data  <= base;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    base_ref = base;
    cfg_index <= gpe_pkg::REG_ZERO_ENTRY;
    cfg_data  <= zero;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    zero_ref = zero;
    cfg_valid <= 1'b0;
  endtask

  // Loads may only land where the right and gate stores already hold something.
  task automatic init_load_lanes();
    int addr;
    int bit_no;
    lane_bits.delete();
    for (int k = 0; k < 9; k++) begin
      case (k)
        0:       bit_no = 0;
        1:       bit_no = STATE_BITS - 1;
        2:       bit_no = 1;
        default: bit_no = $urandom_range(0, STATE_BITS - 1);
      endcase
      addr = int'(base_ref) + bit_no * DEF_INPUT_STRIDE;
      if (addr < DEF_ENTRY_COUNT) begin
        if (!live_map.exists(addr))
          send_word(pool_gate(addr[REF_BITS-1:0]));
        lane_bits = {lane_bits, bit_no};
      end
    end
  endtask

  task automatic run_random(int count);
    repeat (count) send_word(random_item());
  endtask

  task automatic test_directed_items();
    send_word(zero_item());
    send_word(gate_item(1'b0, '1, 0, gpe_pkg::PIN_A, 0, gpe_pkg::PIN_B));
    send_word(gate_item(1'b1, '1, 0, gpe_pkg::PIN_C, '1, gpe_pkg::PIN_C));
    // The right pin reads the target's own left copy, written by the same gate.
    send_word(gate_item(1'b0, 5, '1, gpe_pkg::PIN_B, 5, gpe_pkg::PIN_A));
    send_word(gate_item(1'b1, 5, 0, gpe_pkg::PIN_A, '1, gpe_pkg::PIN_C));
    send_word(gate_item(1'b1, 7, 5, gpe_pkg::PIN_B, 5, gpe_pkg::PIN_C));
    send_word(load_item(0, ALL_ONES));
    send_word(pool_gate(REF_BITS'((STATE_BITS - 1) * DEF_INPUT_STRIDE)));
    send_word(load_item(STATE_BITS - 1, '0));
    send_word(load_item(STATE_BITS, random_word()));
    send_word(load_item(MAX_BIT_INDEX, ALL_ONES));
    send_word(gate_item(1'b0, REF_BITS'($urandom()), '1, gpe_pkg::PIN_BAD, 0, gpe_pkg::PIN_A));
    send_word(gate_item(1'b1, '1, 0, gpe_pkg::PIN_C, '1, gpe_pkg::PIN_BAD));
    send_word(gate_item(1'b0, 0, '1, gpe_pkg::PIN_BAD, '1, gpe_pkg::PIN_BAD));
    send_word(noise_item());
    wait_drained();
    // Highest base: only bit 0 maps into the stores, bit 1 is already out of range.
    set_config('1, '1);
    send_word(zero_item());
    send_word(load_item(0, random_word()));
    send_word(load_item(1, random_word()));
    send_word(load_item(STATE_BITS - 1, random_word()));
    wait_drained();
  endtask

  task automatic test_config_sweep();
    logic [REF_BITS-1:0] base;
    logic [REF_BITS-1:0] zero;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          base = '0;
          zero = '0;
        end
        1: begin
          base = '1;
          zero = '1;
        end
        2: begin
          // Every bit up to the last state bit still lands inside the stores.
          base = REF_BITS'(DEF_ENTRY_COUNT - 1 - (STATE_BITS - 1) * DEF_INPUT_STRIDE);
          zero = REF_BITS'($urandom());
        end
        default: begin
          base = REF_BITS'($urandom());
          zero = REF_BITS'($urandom());
        end
      endcase
      wait_drained();
      set_config(base, zero);
      send_word(zero_item());
      init_load_lanes();
      run_random(170);
    end
    wait_drained();
  endtask

  // The result side holds off while words keep coming, so both queues fill and full rises.
  task automatic test_full_result_queue();
    idle_on = 1'b0;
    hold_request = LONG_HOLD;
    run_random(40);
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    run_random(230);
    wait_drained();
  endtask

  function automatic void compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  task automatic check_word();
    gate_result_t want;
    if (gate_results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result word with nothing expected: ref 0x%0h", out_written_ref);
    end else begin
      want = gate_results_due.pop_front();
      compare_field("status", 64'(out_status), 64'(want.status));
      compare_field("written_ref", 64'(out_written_ref), 64'(want.wref));
      compare_field("left_word", 64'(out_left_word), 64'(want.left_word));
      compare_field("right_word", 64'(out_right_word), 64'(want.right_word));
      compare_field("gate_word", 64'(out_gate_word), 64'(want.gate_word));
    end
  endtask

  // Result side: checks each popped word and stalls in bursts or for one long hold.
  always @(posedge clk) begin
    if (rst_n && out_pop && out_empty === 1'b0)
      check_word();
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_items();
    test_config_sweep();
    test_full_result_queue();
    test_steady_stream();
    if (mismatches == 0 && gate_results_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
